// ===== rtl/qsd_pkg.sv =====
// Shared types, constants and address helpers for the QAP swap delta evaluator.
// Depends on nothing; the MAC, the top level and the testbench files import it.
`timescale 1ns / 1ps
`default_nettype none

package qsd_pkg;

  // Problem size and matrix entry width
  localparam int SIZE        = 32;
  localparam int ENTRY_WIDTH = 16;

  localparam int IDX_W    = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int MAT_DEPTH = SIZE * SIZE;
  localparam int MAT_AW   = $clog2(MAT_DEPTH);

  // Item field widths
  localparam int FUNC_W      = 3;
  localparam int FIELD_IDX_W = 5;
  localparam int VALUE_W     = 16;
  localparam int FIT_W       = 48;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;

  // Arithmetic widths
  localparam int DIFF_W = ENTRY_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_FLOW = 3'd0,
    FN_WR_DIST = 3'd1,
    FN_WR_PERM = 3'd2,
    FN_EVAL    = 3'd3,
    FN_APPLY   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_PERM,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_SW_A,
    ST_SW_B
  } state_t;

  // Which pair of products a delta step covers
  typedef enum logic [1:0] {
    STEP_DIAG,
    STEP_CROSS,
    STEP_COL,
    STEP_ROW
  } step_t;

  typedef struct packed {
    logic                   valid;
    logic [ENTRY_WIDTH-1:0] f0;
    logic [ENTRY_WIDTH-1:0] f1;
    logic [ENTRY_WIDTH-1:0] d0;
    logic [ENTRY_WIDTH-1:0] d1;
  } mac_req_t;

  function automatic logic idx_ok(input logic [FIELD_IDX_W-1:0] x);
    return int'(x) < SIZE;
  endfunction

  function automatic logic val_ok(input logic [VALUE_W-1:0] x);
    return int'(x) < SIZE;
  endfunction

  function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    return MAT_AW'(row) * MAT_AW'(SIZE) + MAT_AW'(col);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qsd_ram.sv =====
// Generic synchronous RAM: one write port, two read ports with registered data.
// Stand-alone; used for the flow, distance and permutation stores.
`timescale 1ns / 1ps
`default_nettype none

module qsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/qsd_mac.sv =====
// Difference, multiply and accumulate pipeline for the swap delta terms.
// Depends on qsd_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module qsd_mac
  import qsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr,
  input  wire mac_req_t         req,
  output logic                  busy,
  output logic      [FIT_W-1:0] acc
);

  logic                     df_v_r;
  logic signed [DIFF_W-1:0] df_f_r;
  logic signed [DIFF_W-1:0] df_d_r;
  logic                     pr_v_r;
  logic signed [PROD_W-1:0] pr_r;
  logic        [FIT_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      df_v_r <= 1'b0;
      pr_v_r <= 1'b0;
    end else begin
      df_v_r <= req.valid;
      pr_v_r <= df_v_r;
    end
  end

  always_ff @(posedge clk) begin
    df_f_r <= $signed({1'b0, req.f0}) - $signed({1'b0, req.f1});
    df_d_r <= $signed({1'b0, req.d0}) - $signed({1'b0, req.d1});
    pr_r   <= df_f_r * df_d_r;
  end

  // Accumulate modulo 2^48
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (pr_v_r) begin
      acc_r <= acc_r + FIT_W'(pr_r);
    end
  end

  assign busy = df_v_r | pr_v_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

// ===== rtl/qap_swap_delta_evaluator_unit.sv =====
// Top level of the QAP swap delta evaluator: stores, step sequencer and handshakes.
// Depends on qsd_pkg, qsd_ram and qsd_mac.
`timescale 1ns / 1ps
`default_nettype none

// Holds the flow matrix, distance matrix and permutation of a SIZE-position
// quadratic assignment problem and evaluates the cost change of swapping two
// positions. Write items (flow, distance, permutation) give no result; an
// apply item reads both permutation entries, then writes them back crossed,
// and gives no result. An evaluate item runs one permutation lookup, then
// 2*SIZE+2 product steps, one per cycle, each reading two flow and two
// distance entries through the two read ports of each matrix memory, then a
// drain until the multiply-accumulate pipeline is empty, then loads the
// result; with an index out of range it skips to loading a zero delta. It
// returns one result. A finished result sits in an output register, so the
// next item is taken while it waits; a new result is loaded only when the
// output register is empty or its result is being taken.
// No reset sweep: every store is undefined until written.
module qap_swap_delta_evaluator_unit
  import qsd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [4:0] first_index, [9:5] second_index, [25:10] value, [73:26] base_fitness
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] func
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [47:0] delta, [95:48] new_fitness
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  // Input fields
  logic [FIELD_IDX_W-1:0] in_first;
  logic [FIELD_IDX_W-1:0] in_second;
  logic [VALUE_W-1:0]     in_value;
  logic [FIT_W-1:0]       in_base;
  func_t                  in_func;
  logic                   in_acc;
  logic                   idx_good;

  assign in_first  = in_tdata[4:0];
  assign in_second = in_tdata[9:5];
  assign in_value  = in_tdata[25:10];
  assign in_base   = in_tdata[73:26];
  assign in_func   = func_t'(in_tuser);
  assign in_acc    = in_tvalid & in_tready;
  assign idx_good  = idx_ok(in_first) & idx_ok(in_second);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] i_r, j_r, pi_r, pj_r;
  logic [FIT_W-1:0] base_r;

  // Step sequencer
  step_t            seq_kind_r;
  logic [IDX_W-1:0] seq_k_r;
  logic             seq_last;
  logic             seq_use;

  // Pipeline between permutation read and matrix read
  logic             p1_v_r;
  step_t            p1_kind_r;
  logic [IDX_W-1:0] p1_k_r;
  logic             p2_v_r;

  // Output register
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_d_r;
  logic                   out_load;

  // Memory ports
  logic [IDX_W-1:0]       pm_raddr_a, pm_raddr_b, pm_rdata_a, pm_rdata_b;
  logic                   pm_we;
  logic [IDX_W-1:0]       pm_waddr, pm_wdata;
  logic                   fl_we, ds_we;
  logic [MAT_AW-1:0]      mat_waddr;
  logic [ENTRY_WIDTH-1:0] mat_wdata;
  logic [MAT_AW-1:0]      fl_ra, fl_rb, ds_ra, ds_rb;
  logic [ENTRY_WIDTH-1:0] fl_da, fl_db, ds_da, ds_db;

  mac_req_t         mac_req;
  logic             mac_busy;
  logic [FIT_W-1:0] mac_acc;
  logic             mac_clr;

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FN_EVAL) begin
            state_nxt = idx_good ? ST_EV_PERM : ST_FINISH;
          end else if (in_func == FN_APPLY && idx_good) begin
            state_nxt = ST_SW_A;
          end
        end
      end
      ST_EV_PERM: state_nxt = ST_RUN;
      ST_RUN: begin
        if (seq_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r && !mac_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SW_A: state_nxt = ST_SW_B;
      ST_SW_B: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready  = 1'b0;
    out_load   = 1'b0;
    pm_raddr_a = seq_k_r;
    pm_we      = 1'b0;
    pm_waddr   = IDX_W'(in_first);
    pm_wdata   = IDX_W'(in_value);
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        pm_raddr_a = IDX_W'(in_first);
        pm_we      = in_acc && in_func == FN_WR_PERM && idx_ok(in_first) && val_ok(in_value);
      end
      ST_FINISH: out_load = !out_v_r || out_tready;
      ST_SW_A: begin
        pm_we    = 1'b1;
        pm_waddr = i_r;
        pm_wdata = pm_rdata_b;
      end
      ST_SW_B: begin
        pm_we    = 1'b1;
        pm_waddr = j_r;
        pm_wdata = pi_r;
      end
      default: ;
    endcase
  end

  assign pm_raddr_b = IDX_W'(in_second);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture item operands
  always_ff @(posedge clk) begin
    if (in_acc) begin
      i_r    <= IDX_W'(in_first);
      j_r    <= IDX_W'(in_second);
      base_r <= in_base;
    end
    if (state_r == ST_EV_PERM) begin
      pi_r <= pm_rdata_a;
      pj_r <= pm_rdata_b;
    end else if (state_r == ST_SW_A) begin
      pi_r <= pm_rdata_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Step sequencer: diagonal, cross, then column and row steps for every k
  assign seq_last = (seq_kind_r == STEP_ROW) && (seq_k_r == IDX_W'(SIZE - 1));
  assign seq_use  = !((seq_kind_r == STEP_COL || seq_kind_r == STEP_ROW) &&
                      (seq_k_r == i_r || seq_k_r == j_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_kind_r <= STEP_DIAG;
      seq_k_r    <= '0;
    end else if (state_r == ST_IDLE) begin
      seq_kind_r <= STEP_DIAG;
      seq_k_r    <= '0;
    end else if (state_r == ST_RUN) begin
      unique case (seq_kind_r)
        STEP_DIAG:  seq_kind_r <= STEP_CROSS;
        STEP_CROSS: seq_kind_r <= STEP_COL;
        STEP_COL:   seq_kind_r <= STEP_ROW;
        STEP_ROW: begin
          seq_kind_r <= STEP_COL;
          seq_k_r    <= seq_k_r + 1'b1;
        end
        default:    seq_kind_r <= STEP_DIAG;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == ST_RUN) && seq_use;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_kind_r <= seq_kind_r;
    p1_k_r    <= seq_k_r;
  end

  // Matrix read addresses; permutation data here is p[k] for this step
  always_comb begin
    unique case (p1_kind_r)
      STEP_DIAG: begin
        fl_ra = mat_addr(i_r, i_r);
        fl_rb = mat_addr(j_r, j_r);
        ds_ra = mat_addr(pj_r, pj_r);
        ds_rb = mat_addr(pi_r, pi_r);
      end
      STEP_CROSS: begin
        fl_ra = mat_addr(i_r, j_r);
        fl_rb = mat_addr(j_r, i_r);
        ds_ra = mat_addr(pj_r, pi_r);
        ds_rb = mat_addr(pi_r, pj_r);
      end
      STEP_COL: begin
        fl_ra = mat_addr(p1_k_r, i_r);
        fl_rb = mat_addr(p1_k_r, j_r);
        ds_ra = mat_addr(pm_rdata_a, pj_r);
        ds_rb = mat_addr(pm_rdata_a, pi_r);
      end
      STEP_ROW: begin
        fl_ra = mat_addr(i_r, p1_k_r);
        fl_rb = mat_addr(j_r, p1_k_r);
        ds_ra = mat_addr(pj_r, pm_rdata_a);
        ds_rb = mat_addr(pi_r, pm_rdata_a);
      end
      default: begin
        fl_ra = '0;
        fl_rb = '0;
        ds_ra = '0;
        ds_rb = '0;
      end
    endcase
  end

  // Matrix writes come straight from accepted items
  assign mat_waddr = mat_addr(IDX_W'(in_first), IDX_W'(in_second));
  assign mat_wdata = in_value[ENTRY_WIDTH-1:0];
  assign fl_we     = in_acc && in_func == FN_WR_FLOW && idx_good;
  assign ds_we     = in_acc && in_func == FN_WR_DIST && idx_good;

  qsd_ram #(.WIDTH(IDX_W), .DEPTH(SIZE)) u_perm_ram (
    .clk     (clk),
    .we      (pm_we),
    .waddr   (pm_waddr),
    .wdata   (pm_wdata),
    .raddr_a (pm_raddr_a),
    .raddr_b (pm_raddr_b),
    .rdata_a (pm_rdata_a),
    .rdata_b (pm_rdata_b)
  );

  qsd_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(MAT_DEPTH)) u_flow_ram (
    .clk     (clk),
    .we      (fl_we),
    .waddr   (mat_waddr),
    .wdata   (mat_wdata),
    .raddr_a (fl_ra),
    .raddr_b (fl_rb),
    .rdata_a (fl_da),
    .rdata_b (fl_db)
  );

  qsd_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(MAT_DEPTH)) u_dist_ram (
    .clk     (clk),
    .we      (ds_we),
    .waddr   (mat_waddr),
    .wdata   (mat_wdata),
    .raddr_a (ds_ra),
    .raddr_b (ds_rb),
    .rdata_a (ds_da),
    .rdata_b (ds_db)
  );

  // ---------------------------------------------------------------------------
  // Multiply-accumulate
  assign mac_clr       = in_acc && in_func == FN_EVAL;
  assign mac_req.valid = p2_v_r;
  assign mac_req.f0    = fl_da;
  assign mac_req.f1    = fl_db;
  assign mac_req.d0    = ds_da;
  assign mac_req.d1    = ds_db;

  qsd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (mac_clr),
    .req   (mac_req),
    .busy  (mac_busy),
    .acc   (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the result until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_d_r <= {base_r + mac_acc, mac_acc};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

`default_nettype wire

// ===== tb/qsd_swap_cost_checker.sv =====
`timescale 1ns / 1ps
// Checker for qap_swap_delta_evaluator_unit: mirrors the flow, distance and permutation
// stores from the input transfers, predicts every swap evaluation and compares results.
// Depends on qsd_pkg.
module qsd_swap_cost_checker
  import qsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [4:0] first_index, [9:5] second_index, [25:10] value, [73:26] base_fitness
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] func
  input  logic [FUNC_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [47:0] delta, [95:48] new_fitness
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            fail_count,
  output int unsigned            open_results
);

  typedef struct {
    logic [FIT_W-1:0] delta;
    logic [FIT_W-1:0] new_cost;
  } swap_cost_t;

  logic [ENTRY_WIDTH-1:0] flow_q [SIZE][SIZE];
  logic [ENTRY_WIDTH-1:0] dist_q [SIZE][SIZE];
  logic [IDX_W-1:0]       perm_q [SIZE];
  swap_cost_t             cost_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t qsd checker: %s", $time, msg);
    fail_count++;
  endtask

  function automatic longint pair_product(input logic [ENTRY_WIDTH-1:0] fa, fb, da, db);
    return (longint'(fa) - longint'(fb)) * (longint'(da) - longint'(db));
  endfunction

  // Cost change of exchanging the locations of positions i and j
  function automatic logic [FIT_W-1:0] swap_cost_change(input int i, input int j);
    longint acc;
    int     li;
    int     lj;
    int     lk;
    li  = perm_q[i];
    lj  = perm_q[j];
    acc = pair_product(flow_q[i][i], flow_q[j][j], dist_q[lj][lj], dist_q[li][li])
        + pair_product(flow_q[i][j], flow_q[j][i], dist_q[lj][li], dist_q[li][lj]);
    for (int k = 0; k < SIZE; k++) begin
      if (k != i && k != j) begin
        lk  = perm_q[k];
        acc += pair_product(flow_q[k][i], flow_q[k][j], dist_q[lk][lj], dist_q[lk][li]);
        acc += pair_product(flow_q[i][k], flow_q[j][k], dist_q[lj][lk], dist_q[li][lk]);
      end
    end
    return acc[FIT_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [FIELD_IDX_W-1:0] a;
    logic [FIELD_IDX_W-1:0] b;
    logic [VALUE_W-1:0]     v;
    logic [FIT_W-1:0]       base;
    logic [FIT_W-1:0]       d;
    logic [FIT_W-1:0]       sum;
    logic [IDX_W-1:0]       t;
    logic                   both_ok;
    swap_cost_t             got;
    swap_cost_t             want;
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        a       = in_tdata[4:0];
        b       = in_tdata[9:5];
        v       = in_tdata[25:10];
        base    = in_tdata[73:26];
        both_ok = int'(a) < SIZE && int'(b) < SIZE;
        case (in_tuser)
          FN_WR_FLOW: if (both_ok) flow_q[a][b] = v[ENTRY_WIDTH-1:0];
          FN_WR_DIST: if (both_ok) dist_q[a][b] = v[ENTRY_WIDTH-1:0];
          FN_WR_PERM: if (int'(a) < SIZE && int'(v) < SIZE) perm_q[a] = v[IDX_W-1:0];
          FN_EVAL: begin
            d = '0;
            if (both_ok) d = swap_cost_change(int'(a), int'(b));
            sum = base + d;
            cost_q.push_back('{d, sum});
          end
          FN_APPLY: if (both_ok) begin
            t         = perm_q[a];
            perm_q[a] = perm_q[b];
            perm_q[b] = t;
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.delta    = out_tdata[FIT_W-1:0];
        got.new_cost = out_tdata[2*FIT_W-1:FIT_W];
        if (cost_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: delta %h new_fitness %h",
                                    got.delta, got.new_cost));
        end else begin
          want = cost_q.pop_front();
          if (got.delta !== want.delta) begin
            report_mismatch($sformatf("delta %h, predicted %h", got.delta, want.delta));
          end
          if (got.new_cost !== want.new_cost) begin
            report_mismatch($sformatf("new_fitness %h, predicted %h",
                                      got.new_cost, want.new_cost));
          end
        end
      end
    end
    open_results = cost_q.size();
  end

endmodule

// ===== tb/tb_qap_swap_delta_evaluator_unit.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for qap_swap_delta_evaluator_unit: loads the stores, then runs
// directed and random write, evaluate and apply transfers. Depends on qsd_pkg, the
// evaluator RTL and qsd_swap_cost_checker.
module tb_qap_swap_delta_evaluator_unit
  import qsd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_PCT     = 16;
  localparam int FUNC_TOP     = (1 << FUNC_W) - 1;
  localparam int VALUE_TOP    = (1 << VALUE_W) - 1;
  localparam logic [FIT_W-1:0] FIT_MAX = {1'b0, {(FIT_W-1){1'b1}}};
  localparam logic [FIT_W-1:0] FIT_MIN = {1'b1, {(FIT_W-1){1'b0}}};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   calm       = 1'b0;
  int unsigned            fail_count;
  int unsigned            open_results;
  int unsigned            cycles     = 0;

  qap_swap_delta_evaluator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  qsd_swap_cost_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random, except during the calm stretch
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_qap_swap_delta_evaluator_unit: FAIL");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(0, 15));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [FIT_W-1:0] rand_base();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return FIT_MAX - FIT_W'($urandom_range(0, 1 << 20));
      1:       return FIT_MIN + FIT_W'($urandom_range(0, 1 << 20));
      2:       return -FIT_W'($urandom_range(0, 1000));
      default: return r[FIT_W-1:0];
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [FIELD_IDX_W-1:0] a,
                           input logic [FIELD_IDX_W-1:0] b, input logic [VALUE_W-1:0] v,
                           input logic [FIT_W-1:0] base);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT / 2) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= IN_TDATA_W'({base, v, b, a});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has been taken
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (open_results != 0);
  endtask

  task automatic load_stores();
    int loc [SIZE];
    int pick;
    int t;
    for (int r = 0; r < SIZE; r++) begin
      for (int c = 0; c < SIZE; c++) begin
        send_item(FN_WR_FLOW, FIELD_IDX_W'(r), FIELD_IDX_W'(c), rand_entry(), rand_base());
      end
    end
    for (int r = 0; r < SIZE; r++) begin
      for (int c = 0; c < SIZE; c++) begin
        send_item(FN_WR_DIST, FIELD_IDX_W'(r), FIELD_IDX_W'(c), rand_entry(), rand_base());
      end
    end
    for (int s = 0; s < SIZE; s++) loc[s] = s;
    for (int s = SIZE - 1; s > 0; s--) begin
      pick      = $urandom_range(0, s);
      t         = loc[s];
      loc[s]    = loc[pick];
      loc[pick] = t;
    end
    for (int s = 0; s < SIZE; s++) begin
      send_item(FN_WR_PERM, FIELD_IDX_W'(s), FIELD_IDX_W'($urandom_range(0, SIZE - 1)),
                VALUE_W'(loc[s]), rand_base());
    end
  endtask

  task automatic run_directed();
    send_item(FN_EVAL, '0, FIELD_IDX_W'(SIZE - 1), '0, '0);
    send_item(FN_EVAL, FIELD_IDX_W'(5), FIELD_IDX_W'(5), '1, rand_base());
    send_item(FN_EVAL, FIELD_IDX_W'(1), FIELD_IDX_W'(2), '0, FIT_MAX);
    send_item(FN_EVAL, FIELD_IDX_W'(2), FIELD_IDX_W'(1), '0, FIT_MIN);
    // location out of range: must leave the permutation untouched
    send_item(FN_WR_PERM, FIELD_IDX_W'(3), '0, VALUE_W'(SIZE), '0);
    send_item(FN_WR_PERM, FIELD_IDX_W'(4), '0, '1, '0);
    send_item(FN_EVAL, FIELD_IDX_W'(3), FIELD_IDX_W'(4), '0, '0);
    send_item(FN_APPLY, '0, FIELD_IDX_W'(SIZE - 1), '0, '0);
    send_item(FN_APPLY, FIELD_IDX_W'(7), FIELD_IDX_W'(7), '0, '0);
    send_item(FN_EVAL, '0, FIELD_IDX_W'(SIZE - 1), '0, '1);
    for (int fn = FN_APPLY + 1; fn <= FUNC_TOP; fn++) begin
      send_item(FUNC_W'(fn), FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom),
                VALUE_W'($urandom), rand_base());
    end
    send_item(FN_WR_FLOW, '0, FIELD_IDX_W'(SIZE - 1), '1, FIT_MAX);
    send_item(FN_WR_FLOW, FIELD_IDX_W'(SIZE - 1), '0, '0, FIT_MIN);
    send_item(FN_WR_DIST, FIELD_IDX_W'(SIZE - 1), FIELD_IDX_W'(SIZE - 1), '1, '0);
    send_item(FN_WR_DIST, '0, '0, '0, '0);
    send_item(FN_EVAL, '0, FIELD_IDX_W'(SIZE - 1), '0, FIT_MAX);
    send_item(FN_EVAL, FIELD_IDX_W'(SIZE - 1), '0, '1, FIT_MIN);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned            done_items;
    int unsigned            pick;
    logic [FIELD_IDX_W-1:0] a;
    logic [FIELD_IDX_W-1:0] b;
    done_items = 0;
    while (done_items < n) begin
      pick = $urandom_range(0, 99);
      a    = FIELD_IDX_W'($urandom_range(0, SIZE - 1));
      b    = FIELD_IDX_W'($urandom_range(0, SIZE - 1));
      if ((pick >= 47 && pick < 92) && $urandom_range(0, 19) == 0) b = a;
      if (pick < 22) begin
        send_item(FN_WR_FLOW, a, b, rand_entry(), rand_base());
        done_items++;
      end else if (pick < 37) begin
        send_item(FN_WR_DIST, a, b, rand_entry(), rand_base());
        done_items++;
      end else if (pick < 47) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(FN_WR_PERM, a, b, VALUE_W'($urandom_range(SIZE, VALUE_TOP)),
                    rand_base());
        end else begin
          send_item(FN_WR_PERM, a, b, VALUE_W'($urandom_range(0, SIZE - 1)), rand_base());
          done_items++;
        end
      end else if (pick < 77) begin
        send_item(FN_EVAL, a, b, VALUE_W'($urandom), rand_base());
        done_items++;
      end else if (pick < 92) begin
        send_item(FN_APPLY, a, b, VALUE_W'($urandom), rand_base());
        done_items++;
      end else begin
        send_item(FUNC_W'($urandom_range(FN_APPLY + 1, FUNC_TOP)), a, b,
                  VALUE_W'($urandom), rand_base());
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    load_stores();
    run_directed();
    hold_until_drained();
    run_random(100);
    calm <= 1'b1;
    run_random(80);
    calm <= 1'b0;
    run_random(60);
    hold_until_drained();
    run_random(80);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_qap_swap_delta_evaluator_unit: PASS");
    end else begin
      $display("tb_qap_swap_delta_evaluator_unit: FAIL");
    end
    $finish;
  end

endmodule
